// ===== hdl/jts_pkg.sv =====
// Package for the JSON token scanner: byte classes, token kinds, scan modes,
// the classified item that crosses the inner queue, and keyword helpers.
// Depends on nothing; the top level, jts_front and jts_back import it.
`default_nettype none

package jts_pkg;

	localparam int DEF_LINE_BITS       = 24;
	localparam int DEF_FRAC_BITS       = 16;
	localparam int DEF_MAX_FRAC_DIGITS = 5;

	// Depth of the queue between front and back, and of the result queue.
	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;

	localparam int INT_BITS = 31;

	typedef enum logic [2:0] {
		CLS_SPACE = 3'd0,
		CLS_LF    = 3'd1,
		CLS_CR    = 3'd2,
		CLS_QUOTE = 3'd3,
		CLS_ALPHA = 3'd4,
		CLS_DIGIT = 3'd5,
		CLS_DOT   = 3'd6,
		CLS_OTHER = 3'd7
	} cls_t;

	typedef enum logic [3:0] {
		K_CHAR  = 4'd0,
		K_SBYTE = 4'd1,
		K_SEND  = 4'd2,
		K_TRUE  = 4'd3,
		K_FALSE = 4'd4,
		K_NULL  = 4'd5,
		K_INT   = 4'd6,
		K_REAL  = 4'd7,
		K_END   = 4'd8
	} kind_t;

	typedef enum logic [4:0] {
		M_IDLE   = 5'b00001,
		M_STRING = 5'b00010,
		M_WORD   = 5'b00100,
		M_INT    = 5'b01000,
		M_FRAC   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic       eoi;
		cls_t       cls;
		logic [7:0] ch;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	typedef struct packed {
		logic [2:0] len;
		logic [2:0] cand;
	} word_t;

	function automatic logic [7:0] kw_true_at(input logic [2:0] p);
		logic [7:0] c;
		case (p)
			3'd0:    c = "t";
			3'd1:    c = "r";
			3'd2:    c = "u";
			3'd3:    c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_false_at(input logic [2:0] p);
		logic [7:0] c;
		case (p)
			3'd0:    c = "f";
			3'd1:    c = "a";
			3'd2:    c = "l";
			3'd3:    c = "s";
			3'd4:    c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_null_at(input logic [2:0] p);
		logic [7:0] c;
		case (p)
			3'd0:    c = "n";
			3'd1:    c = "u";
			3'd2:    c = "l";
			3'd3:    c = "l";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Appends one letter to a word: drops the keywords it no longer matches.
	function automatic word_t word_step(input logic [2:0] p, input logic [2:0] cand,
			input logic [7:0] ch);
		word_t w;
		w.cand    = cand;
		w.cand[0] = cand[0] && (ch == kw_true_at(p));
		w.cand[1] = cand[1] && (ch == kw_false_at(p));
		w.cand[2] = cand[2] && (ch == kw_null_at(p));
		w.len     = (p == 3'd7) ? 3'd7 : p + 3'd1;
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/json_token_scanner.sv =====
// Channel   Handshake        Payload                     Beat
// input     push / full      char_byte, end_of_input     one text byte
// result    pop / empty      token_kind                  one token
//
// One byte is taken each cycle while full is low; the back part scans one byte
// per cycle from the inner queue while the result queue has room for the two
// tokens a byte may give. A byte that gives two tokens needs two result beats,
// so the pop side sets the rate. A byte waits in the inner queue until scanned,
// and any token it gives is registered in the result queue as it is scanned.
// Reset clears all scanner state at once; the line count restarts at one.
// Both queues hold four entries; full and empty only reflect their fill.
// Top level of the JSON token scanner; instantiates jts_front, jts_fifo and
// jts_back, and depends on jts_pkg.
`default_nettype none

module json_token_scanner #(
	parameter int LINE_BITS       = jts_pkg::DEF_LINE_BITS,
	parameter int FRAC_BITS       = jts_pkg::DEF_FRAC_BITS,
	parameter int MAX_FRAC_DIGITS = jts_pkg::DEF_MAX_FRAC_DIGITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_byte,
	input  wire logic       end_of_input,
	output logic            empty,
	input  wire logic       pop,
	output logic [3:0]      token_kind
);
	import jts_pkg::*;

	logic              q_push, q_pop, q_full, q_empty;
	item_t             q_in, q_out;
	logic [ITEM_W-1:0] q_dout;

	jts_front u_front (
		.push         (push),
		.full         (full),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.q_push       (q_push),
		.q_item       (q_in),
		.q_full       (q_full)
	);

	jts_fifo #(
		.DEPTH (IQ_DEPTH),
		.WIDTH (ITEM_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign q_out = item_t'(q_dout);

	jts_back #(
		.LINE_BITS       (LINE_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_item     (q_out),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.token_kind (token_kind)
	);

`ifndef SYNTHESIS
	a_back_pops_only_filled: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back part took a byte from an empty queue");

	a_queue_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("inner queue reports full and empty together");

	a_beat_lands_in_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && q_empty) |=> !q_empty)
		else $error("accepted beat did not reach the inner queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/jts_fifo.sv =====
// Small synchronous queue of fixed-width entries, one push and one pop a cycle.
// Carries classified bytes from front to back. Depends on nothing.
`default_nettype none

module jts_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/jts_front.sv =====
// Front part of the scanner: takes input beats and sorts each byte into a class.
// Depends on jts_pkg.
`default_nettype none

module jts_front (
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    char_byte,
	input  wire logic          end_of_input,
	output logic               q_push,
	output jts_pkg::item_t     q_item,
	input  wire logic          q_full
);
	import jts_pkg::*;

	cls_t cls;

	always_comb begin
		if (char_byte == " " || char_byte == 8'h09) begin
			cls = CLS_SPACE;
		end else if (char_byte == 8'h0A) begin
			cls = CLS_LF;
		end else if (char_byte == 8'h0D) begin
			cls = CLS_CR;
		end else if (char_byte == 8'h22) begin
			cls = CLS_QUOTE;
		end else if ((char_byte >= "a" && char_byte <= "z") ||
				(char_byte >= "A" && char_byte <= "Z")) begin
			cls = CLS_ALPHA;
		end else if (char_byte >= "0" && char_byte <= "9") begin
			cls = CLS_DIGIT;
		end else if (char_byte == ".") begin
			cls = CLS_DOT;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign full       = q_full;
	assign q_push     = push && !q_full;
	assign q_item.eoi = end_of_input;
	assign q_item.cls = cls;
	assign q_item.ch  = char_byte;

endmodule

`default_nettype wire

// ===== hdl/jts_back.sv =====
// Back part of the scanner: the token state machine, line and number state,
// and the result queue that holds up to two tokens from each byte.
// Depends on jts_pkg.
`default_nettype none

module jts_back #(
	parameter int LINE_BITS       = jts_pkg::DEF_LINE_BITS,
	parameter int FRAC_BITS       = jts_pkg::DEF_FRAC_BITS,
	parameter int MAX_FRAC_DIGITS = jts_pkg::DEF_MAX_FRAC_DIGITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire jts_pkg::item_t q_item,
	input  wire logic           q_empty,
	output logic                q_pop,
	output logic                empty,
	input  wire logic           pop,
	output logic [3:0]          token_kind
);
	import jts_pkg::*;

	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam int SUM_W    = FRAC_BITS + 6;
	localparam int NUM_W    = INT_BITS + 4;
	localparam logic [FRAC_BITS:0] FRAC_CAP = '1;

	// Weight of fraction digit k (from 0), round(2^FRAC_BITS / 10^(k+1)), by digit count.
	logic [FRAC_BITS:0] w_tab [8];
	for (genvar k = 0; k < 8; k++) begin : g_weight
		localparam longint unsigned P = 64'd10 ** (k + 1);
		localparam longint unsigned W = (k < MAX_FRAC_DIGITS) ?
			((((64'd1 << (FRAC_BITS + 1)) / P) + 64'd1) >> 1) : 64'd0;
		assign w_tab[k] = (FRAC_BITS + 1)'(W);
	end

	mode_t                mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [INT_BITS-1:0]  int_q, int_d;
	logic [FRAC_BITS:0]   frac_q, frac_d;
	logic [2:0]           fcnt_q, fcnt_d;
	logic [2:0]           wlen_q, wlen_d;
	logic [2:0]           cand_q, cand_d;
	logic                 ovf_q, ovf_d;
	logic                 cr_q, cr_d;

	logic [OQ_CNT_W-1:0]  oq_cnt_q;
	logic [OQ_PTR_W-1:0]  oq_wr_q, oq_rd_q;
	kind_t                oq_mem_q [OQ_DEPTH];

	word_t                wa;
	logic                 in_word;
	logic [3:0]           digit;
	logic [NUM_W-1:0]     num;
	logic [SUM_W-1:0]     fsum;
	logic                 flush_v;
	kind_t                flush_k;
	logic                 f_v, s_v, do_idle;
	kind_t                s_k, tok0;
	logic [1:0]           n_tok;
	logic                 out_pop;

	assign in_word = (mode_q == M_WORD);
	assign wa      = word_step(in_word ? wlen_q : 3'd0, in_word ? cand_q : 3'b111, q_item.ch);
	assign digit   = q_item.ch[3:0];
	assign num     = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + NUM_W'(digit);
	assign fsum    = SUM_W'(frac_q) + SUM_W'(digit) * SUM_W'(w_tab[fcnt_q]);

	// The token a pending word, number or string gives when something ends it.
	always_comb begin
		flush_v = 1'b0;
		flush_k = K_CHAR;
		unique case (mode_q)
			M_STRING: begin
				flush_v = 1'b1;
				flush_k = K_SEND;
			end
			M_WORD: begin
				if (cand_q[0] && wlen_q == 3'd4) begin
					flush_v = 1'b1;
					flush_k = K_TRUE;
				end else if (cand_q[1] && wlen_q == 3'd5) begin
					flush_v = 1'b1;
					flush_k = K_FALSE;
				end else if (cand_q[2] && wlen_q == 3'd4) begin
					flush_v = 1'b1;
					flush_k = K_NULL;
				end
			end
			M_INT: begin
				flush_v = 1'b1;
				flush_k = K_INT;
			end
			M_FRAC: begin
				flush_v = 1'b1;
				flush_k = K_REAL;
			end
			default: begin
				flush_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		line_d  = line_q;
		int_d   = int_q;
		frac_d  = frac_q;
		fcnt_d  = fcnt_q;
		wlen_d  = wlen_q;
		cand_d  = cand_q;
		ovf_d   = ovf_q;
		cr_d    = 1'b0;
		do_idle = 1'b0;
		f_v     = 1'b0;
		s_v     = 1'b0;
		s_k     = K_CHAR;
		if (q_item.eoi) begin
			f_v    = flush_v;
			s_v    = 1'b1;
			s_k    = K_END;
			mode_d = M_IDLE;
		end else begin
			unique case (mode_q)
				M_STRING: begin
					s_v = 1'b1;
					if (q_item.cls == CLS_QUOTE) begin
						s_k    = K_SEND;
						mode_d = M_IDLE;
					end else begin
						s_k = K_SBYTE;
					end
				end
				M_WORD: begin
					if (q_item.cls == CLS_ALPHA) begin
						wlen_d = wa.len;
						cand_d = wa.cand;
					end else begin
						f_v     = flush_v;
						do_idle = 1'b1;
					end
				end
				M_INT: begin
					if (q_item.cls == CLS_DIGIT) begin
						if (num[NUM_W-1:INT_BITS] != '0) begin
							int_d = '1;
							ovf_d = 1'b1;
						end else begin
							int_d = num[INT_BITS-1:0];
						end
					end else if (q_item.cls == CLS_DOT) begin
						mode_d = M_FRAC;
						frac_d = '0;
						fcnt_d = '0;
					end else begin
						f_v     = flush_v;
						do_idle = 1'b1;
					end
				end
				M_FRAC: begin
					if (q_item.cls == CLS_DIGIT) begin
						if (fcnt_q < 3'(MAX_FRAC_DIGITS)) begin
							fcnt_d = fcnt_q + 3'd1;
							frac_d = (fsum > SUM_W'(FRAC_CAP)) ? FRAC_CAP : fsum[FRAC_BITS:0];
						end
					end else begin
						f_v     = flush_v;
						do_idle = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
			if (do_idle) begin
				mode_d = M_IDLE;
				unique case (q_item.cls) inside
					CLS_SPACE: begin
						mode_d = M_IDLE;
					end
					CLS_LF: begin
						// The LF of a CR-LF pair was counted with the CR.
						if (!cr_q) begin
							line_d = line_q + 1'b1;
						end
					end
					CLS_CR: begin
						line_d = line_q + 1'b1;
						cr_d   = 1'b1;
					end
					CLS_QUOTE: begin
						mode_d = M_STRING;
					end
					CLS_ALPHA: begin
						mode_d = M_WORD;
						wlen_d = wa.len;
						cand_d = wa.cand;
					end
					CLS_DIGIT: begin
						mode_d = M_INT;
						int_d  = INT_BITS'(digit);
						frac_d = '0;
						fcnt_d = '0;
						ovf_d  = 1'b0;
					end
					CLS_DOT, CLS_OTHER: begin
						s_v = 1'b1;
						s_k = K_CHAR;
					end
					default: begin
						s_v = 1'b1;
						s_k = K_CHAR;
					end
				endcase
			end
		end
	end

	// A byte is taken only when the result queue has room for two tokens.
	assign q_pop   = !q_empty && (oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign tok0    = f_v ? flush_k : s_k;
	assign n_tok   = q_pop ? (2'(f_v) + 2'(s_v)) : 2'd0;
	assign empty   = (oq_cnt_q == '0);
	assign out_pop = pop && !empty;
	assign token_kind = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (n_tok != 2'd0) begin
			oq_mem_q[oq_wr_q] <= tok0;
		end
		if (n_tok == 2'd2) begin
			oq_mem_q[oq_wr_q + 1'b1] <= s_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			line_q   <= LINE_BITS'(1);
			int_q    <= '0;
			frac_q   <= '0;
			fcnt_q   <= '0;
			wlen_q   <= '0;
			cand_q   <= '0;
			ovf_q    <= 1'b0;
			cr_q     <= 1'b0;
			oq_cnt_q <= '0;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
		end else begin
			if (q_pop) begin
				mode_q <= mode_d;
				line_q <= line_d;
				int_q  <= int_d;
				frac_q <= frac_d;
				fcnt_q <= fcnt_d;
				wlen_q <= wlen_d;
				cand_q <= cand_d;
				ovf_q  <= ovf_d;
				cr_q   <= cr_d;
			end
			oq_wr_q  <= oq_wr_q + OQ_PTR_W'(n_tok);
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(n_tok) - OQ_CNT_W'(out_pop);
		end
	end

endmodule

`default_nettype wire
